[rtl/core/bra_pkg.sv]
package bra_pkg;

   localparam int PAGE_SLOTS = 64;
   localparam int SLOT_BITS  = 6;
   localparam int LEN_BITS   = 4;
   localparam int INDEX_BITS = 10;
   localparam int PAGE_BITS  = INDEX_BITS - SLOT_BITS;

   localparam logic [PAGE_SLOTS-1:0] FULL_MAP = 64'hFFFF_FFFF_FFFF_FFFF;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_SPACE = 2'd1;
   localparam logic [1:0] ST_BAD_LEN  = 2'd2;

   typedef struct packed {
      logic                  valid;
      logic                  hit;
      logic [SLOT_BITS-1:0]  slot;
      logic [PAGE_SLOTS-1:0] map;
   } scan_result_type;

   function automatic logic [PAGE_SLOTS-1:0] run_mask(input logic [LEN_BITS-1:0] len);
      run_mask = ~(FULL_MAP << len);
   endfunction

endpackage

[rtl/core/bitmap_run_allocator.sv]
// Allocate: pages are read one per cycle from the map RAM, starting at page 0; the
//   first page with room is granted, and no space is returned after the last page.
// Free: read, modify, write back. Bad length: goes straight to the result.
// One item in flight; the next beat can be taken once the result is registered.
// Reset (synchronous): a clearing pass writes every page map to zero, one page per
//   cycle; req_ready stays low meanwhile.
module bitmap_run_allocator #(
   parameter int NUM_PAGES = 16,
   parameter int MAX_RUN   = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_cmd,
   input  logic [bra_pkg::LEN_BITS-1:0]      req_run_length,
   input  logic [bra_pkg::INDEX_BITS-1:0]    req_start_index,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_status,
   output logic [bra_pkg::INDEX_BITS-1:0]    rsp_slot_index
);

   localparam int AW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
   localparam logic [AW-1:0] LAST_PAGE = AW'(NUM_PAGES - 1);

   localparam logic [2:0] S_CLR  = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_FRD  = 3'd3;
   localparam logic [2:0] S_FWR  = 3'd4;
   localparam logic [2:0] S_FIN  = 3'd5;

   logic [2:0]                      state_ff, state_in;
   logic [AW-1:0]                   clr_ff, clr_in;
   logic [AW-1:0]                   issue_ff, issue_in;
   logic                            issue_done_ff, issue_done_in;
   logic                            rv_ff, rv_in;
   logic [AW-1:0]                   rp_ff, rp_in;
   logic [AW-1:0]                   sp_ff;
   logic [bra_pkg::LEN_BITS-1:0]    len_ff, len_in;
   logic [bra_pkg::INDEX_BITS-1:0]  start_ff, start_in;
   logic [1:0]                      pend_status_ff, pend_status_in;
   logic [bra_pkg::INDEX_BITS-1:0]  pend_slot_ff, pend_slot_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [1:0]                      rsp_status_ff, rsp_status_in;
   logic [bra_pkg::INDEX_BITS-1:0]  rsp_slot_ff, rsp_slot_in;

   logic                            ram_we, ram_re;
   logic [AW-1:0]                   ram_waddr, ram_raddr;
   logic [bra_pkg::PAGE_SLOTS-1:0]  ram_wdata, ram_rdata;
   bra_pkg::scan_result_type        scan;

   logic                            req_fire;
   logic                            bad_len;
   logic [bra_pkg::PAGE_BITS-1:0]   req_page, free_page;
   logic                            req_in_range;
   logic [AW-1:0]                   free_addr;
   logic [bra_pkg::SLOT_BITS-1:0]   free_off;
   logic [bra_pkg::PAGE_SLOTS-1:0]  len_run;
   logic                            out_free;

   assign req_ready    = (state_ff == S_IDLE);
   assign req_fire     = req_valid && req_ready;
   assign bad_len      = (req_run_length == '0) || (32'(req_run_length) > MAX_RUN);
   assign req_page     = req_start_index[bra_pkg::INDEX_BITS-1:bra_pkg::SLOT_BITS];
   assign req_in_range = 32'(req_page) < NUM_PAGES;
   assign free_page    = start_ff[bra_pkg::INDEX_BITS-1:bra_pkg::SLOT_BITS];
   assign free_addr    = AW'(free_page);
   assign free_off     = start_ff[bra_pkg::SLOT_BITS-1:0];
   assign len_run      = bra_pkg::run_mask(len_ff);
   assign out_free     = !rsp_valid_ff || rsp_ready;

   bra_ram #(
      .WIDTH (bra_pkg::PAGE_SLOTS),
      .DEPTH (NUM_PAGES)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   bra_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (rv_ff && (state_ff == S_SCAN)),
      .in_map     (ram_rdata),
      .run_length (len_ff),
      .result     (scan)
   );

   // map RAM ports
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = clr_ff;
      ram_wdata = '0;
      ram_re    = 1'b0;
      ram_raddr = issue_ff;
      unique case (state_ff)
         S_CLR: begin
            ram_we = 1'b1;
         end
         S_SCAN: begin
            ram_re = !issue_done_ff;
            if (scan.valid && scan.hit) begin
               ram_we    = 1'b1;
               ram_waddr = sp_ff;
               ram_wdata = scan.map | (len_run << scan.slot);
            end
         end
         S_FRD: begin
            ram_re    = 1'b1;
            ram_raddr = free_addr;
         end
         S_FWR: begin
            ram_we    = 1'b1;
            ram_waddr = free_addr;
            ram_wdata = ram_rdata & ~(len_run << free_off);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      issue_in       = issue_ff;
      issue_done_in  = issue_done_ff;
      rv_in          = 1'b0;
      rp_in          = issue_ff;
      len_in         = len_ff;
      start_in       = start_ff;
      pend_status_in = pend_status_ff;
      pend_slot_in   = pend_slot_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_slot_in    = rsp_slot_ff;
      unique case (state_ff)
         S_CLR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_PAGE) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               len_in        = req_run_length;
               start_in      = req_start_index;
               issue_in      = '0;
               issue_done_in = 1'b0;
               pend_slot_in  = '0;
               pend_status_in = bra_pkg::ST_OK;
               if (bad_len) begin
                  pend_status_in = bra_pkg::ST_BAD_LEN;
                  state_in       = S_FIN;
               end else if (req_cmd == bra_pkg::CMD_ALLOC) begin
                  state_in = S_SCAN;
               end else if (req_in_range) begin
                  state_in = S_FRD;
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_SCAN: begin
            if (!issue_done_ff) begin
               rv_in    = 1'b1;
               issue_in = issue_ff + 1'b1;
               if (issue_ff == LAST_PAGE) begin
                  issue_done_in = 1'b1;
               end
            end
            if (scan.valid && scan.hit) begin
               pend_status_in = bra_pkg::ST_OK;
               pend_slot_in   = bra_pkg::INDEX_BITS'({sp_ff, scan.slot});
               state_in       = S_FIN;
            end else if (scan.valid && (sp_ff == LAST_PAGE)) begin
               pend_status_in = bra_pkg::ST_NO_SPACE;
               pend_slot_in   = '0;
               state_in       = S_FIN;
            end
         end
         S_FRD: begin
            state_in = S_FWR;
         end
         S_FWR: begin
            state_in = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_slot_in   = pend_slot_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLR;
         clr_ff        <= '0;
         issue_done_ff <= 1'b0;
         rv_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         issue_done_ff <= issue_done_in;
         rv_ff         <= rv_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      issue_ff       <= issue_in;
      rp_ff          <= rp_in;
      sp_ff          <= rp_ff;
      len_ff         <= len_in;
      start_ff       <= start_in;
      pend_status_ff <= pend_status_in;
      pend_slot_ff   <= pend_slot_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_slot_ff    <= rsp_slot_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot_index = rsp_slot_ff;

`ifndef SYNTHESIS
   a_no_req_during_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLR) |-> !req_ready)
      else $error("request taken during map clear");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (32'(ram_waddr) < NUM_PAGES))
      else $error("map write beyond last page");

   a_slot_zero_unless_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != bra_pkg::ST_OK)) |-> (rsp_slot_ff == '0))
      else $error("nonzero slot index on failed beat");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("second item taken while one is in flight");
`endif

endmodule

[rtl/core/bra_ram.sv]
module bra_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/bra_scan.sv]
module bra_scan (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  logic [bra_pkg::PAGE_SLOTS-1:0]   in_map,
   input  logic [bra_pkg::LEN_BITS-1:0]     run_length,
   output bra_pkg::scan_result_type         result
);

   logic [bra_pkg::PAGE_SLOTS-1:0] fit_in;
   logic [bra_pkg::PAGE_SLOTS-1:0] fit_ff;
   logic [bra_pkg::PAGE_SLOTS-1:0] map_ff;
   logic                           valid_ff;
   logic [bra_pkg::SLOT_BITS-1:0]  slot;
   logic [bra_pkg::PAGE_SLOTS-1:0] run;

   assign run = bra_pkg::run_mask(run_length);

   // fit[s]: run starting at slot s lies in the page and is all free
   always_comb begin
      for (int s = 0; s < bra_pkg::PAGE_SLOTS; s++) begin
         fit_in[s] = ((in_map & (run << s)) == '0) &&
                     ((7'(s) + 7'(run_length)) <= 7'(bra_pkg::PAGE_SLOTS));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      fit_ff <= fit_in;
      map_ff <= in_map;
   end

   // lowest fitting start
   always_comb begin
      slot = '0;
      for (int s = bra_pkg::PAGE_SLOTS - 1; s >= 0; s--) begin
         if (fit_ff[s]) begin
            slot = bra_pkg::SLOT_BITS'(s);
         end
      end
   end

   assign result.valid = valid_ff;
   assign result.hit   = |fit_ff;
   assign result.slot  = slot;
   assign result.map   = map_ff;

endmodule

[tb/tb_top.sv]
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PAGES       = 16;
   localparam int LONGEST_RUN = 8;
   localparam int ITEMS       = 1500;

   typedef struct packed {
      logic                           cmd;
      logic [bra_pkg::LEN_BITS-1:0]   run_length;
      logic [bra_pkg::INDEX_BITS-1:0] start_index;
   } alloc_req_type;

   typedef struct packed {
      logic [1:0]                     status;
      logic [bra_pkg::INDEX_BITS-1:0] slot_index;
   } grant_type;

   typedef enum int {RX_OPEN, RX_CHOPPY, RX_CHOKED} rx_mode_type;
   typedef enum int {MIX_FILL, MIX_CHURN, MIX_DRAIN} mix_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic                           req_cmd = bra_pkg::CMD_ALLOC;
   logic [bra_pkg::LEN_BITS-1:0]   req_run_length = '0;
   logic [bra_pkg::INDEX_BITS-1:0] req_start_index = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [1:0]                     rsp_status;
   logic [bra_pkg::INDEX_BITS-1:0] rsp_slot_index;

   logic [bra_pkg::PAGE_SLOTS-1:0] page_map [PAGES];
   alloc_req_type                  req_backlog [$];
   grant_type                      predicted_grants [$];
   alloc_req_type                  next_req;
   grant_type                      want;
   int                             gap_left = 0;
   int                             burst_left = 0;
   int                             stall_left = 0;
   rx_mode_type                    rx_mode = RX_OPEN;
   int                             error_count = 0;
   int                             beats_checked = 0;
   int                             granted = 0;
   int                             no_space = 0;
   int                             bad_len = 0;
   int                             frees = 0;

   bitmap_run_allocator #(
      .NUM_PAGES(PAGES),
      .MAX_RUN  (LONGEST_RUN)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_run_length (req_run_length),
      .req_start_index(req_start_index),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_slot_index (rsp_slot_index)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // first-fit search over the shadow maps; updates them as the block would
   function automatic grant_type apply_request(input alloc_req_type r);
      grant_type                      g;
      logic [bra_pkg::PAGE_SLOTS-1:0] run;
      logic [bra_pkg::PAGE_SLOTS-1:0] m;
      bit                             found;
      g.status     = bra_pkg::ST_OK;
      g.slot_index = '0;
      found        = 1'b0;
      run          = (64'd1 << r.run_length) - 64'd1;
      if (r.run_length == 0 || r.run_length > LONGEST_RUN) begin
         g.status = bra_pkg::ST_BAD_LEN;
      end else if (r.cmd == bra_pkg::CMD_ALLOC) begin
         g.status = bra_pkg::ST_NO_SPACE;
         for (int p = 0; p < PAGES && !found; p++) begin
            if (page_map[p] != bra_pkg::FULL_MAP) begin
               for (int s = 0; s + r.run_length <= bra_pkg::PAGE_SLOTS && !found; s++) begin
                  m = run << s;
                  if ((page_map[p] & m) == '0) begin
                     page_map[p] |= m;
                     g.slot_index = bra_pkg::INDEX_BITS'(p * bra_pkg::PAGE_SLOTS + s);
                     g.status     = bra_pkg::ST_OK;
                     found        = 1'b1;
                  end
               end
            end
         end
      end else if (int'(r.start_index[bra_pkg::INDEX_BITS-1:bra_pkg::SLOT_BITS]) < PAGES) begin
         // shift drops bits past the page end
         page_map[r.start_index[bra_pkg::INDEX_BITS-1:bra_pkg::SLOT_BITS]] &=
            ~(run << r.start_index[bra_pkg::SLOT_BITS-1:0]);
      end
      return g;
   endfunction

   task automatic queue_req(input logic cmd, input int len, input int idx);
      alloc_req_type r;
      r.cmd         = cmd;
      r.run_length  = bra_pkg::LEN_BITS'(len);
      r.start_index = bra_pkg::INDEX_BITS'(idx);
      req_backlog.push_back(r);
   endtask

   function automatic int pick_len();
      if ($urandom_range(0, 19) == 0)
         return $urandom_range(0, 1) ? 0 : $urandom_range(9, 15);
      return $urandom_range(1, 8);
   endfunction

   // driver: bursts of beats separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         foreach (page_map[p]) page_map[p] = '0;
      end else begin
         if (req_valid && req_ready) begin
            next_req.cmd         = req_cmd;
            next_req.run_length  = req_run_length;
            next_req.start_index = req_start_index;
            predicted_grants.push_back(apply_request(next_req));
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (req_backlog.size() > 0) begin
               next_req = req_backlog.pop_front();
               req_valid       <= 1'b1;
               req_cmd         <= next_req.cmd;
               req_run_length  <= next_req.run_length;
               req_start_index <= next_req.start_index;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 80)
                                                         : $urandom_range(1, 8);
                  gap_left   = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 25);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (stall_left > 0) begin
            stall_left--;
         end else begin
            rx_mode    = rx_mode_type'($urandom_range(0, 2));
            stall_left = $urandom_range(20, 200);
         end
         case (rx_mode)
            RX_OPEN: begin
               rsp_ready <= 1'b1;
            end
            RX_CHOPPY: begin
               rsp_ready <= 1'($urandom_range(0, 1));
            end
            default: begin
               rsp_ready <= ($urandom_range(0, 7) == 0);
            end
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_grants.size() == 0) begin
            $error("unexpected result beat: status %0d slot_index %0d",
                   rsp_status, rsp_slot_index);
            error_count++;
         end else begin
            want = predicted_grants.pop_front();
            beats_checked++;
            case (want.status)
               bra_pkg::ST_NO_SPACE: no_space++;
               bra_pkg::ST_BAD_LEN:  bad_len++;
               default: begin
               end
            endcase
            if (rsp_status != want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_slot_index != want.slot_index) begin
               $error("slot_index: expected %0d, got %0d", want.slot_index, rsp_slot_index);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready && req_run_length != 0 &&
          req_run_length <= LONGEST_RUN) begin
         if (req_cmd == bra_pkg::CMD_FREE) frees++;
         else granted++;
      end
   end

   initial begin
      int      n;
      int      page;
      mix_type mix;

      // bad lengths on both commands
      queue_req(bra_pkg::CMD_ALLOC, 0, 0);
      queue_req(bra_pkg::CMD_FREE, 0, 1023);
      queue_req(bra_pkg::CMD_ALLOC, 9, 0);
      queue_req(bra_pkg::CMD_ALLOC, 15, 'h2AA);
      queue_req(bra_pkg::CMD_FREE, 12, 'h155);
      // fill page 0 and spill into page 1
      repeat (9) queue_req(bra_pkg::CMD_ALLOC, 8, 1023);
      // free running past the end of page 0, then runs must not cross pages
      queue_req(bra_pkg::CMD_FREE, 8, 60);
      queue_req(bra_pkg::CMD_ALLOC, 5, 0);
      queue_req(bra_pkg::CMD_ALLOC, 4, 0);
      queue_req(bra_pkg::CMD_ALLOC, 1, 0);
      // free of already free slots, free at the very last slot
      queue_req(bra_pkg::CMD_FREE, 8, 500);
      queue_req(bra_pkg::CMD_FREE, 8, 1023);
      queue_req(bra_pkg::CMD_FREE, 1, 0);
      queue_req(bra_pkg::CMD_ALLOC, 1, 0);
      queue_req(bra_pkg::CMD_FREE, 3, 2);
      queue_req(bra_pkg::CMD_ALLOC, 2, 'h155);

      mix = MIX_FILL;
      while (req_backlog.size() < ITEMS) begin
         case (mix)
            MIX_FILL: begin
               n = $urandom_range(150, 300);
               repeat (n) begin
                  if ($urandom_range(0, 19) == 0)
                     queue_req(bra_pkg::CMD_FREE, pick_len(), $urandom_range(0, 1023));
                  else
                     queue_req(bra_pkg::CMD_ALLOC, pick_len(), $urandom_range(0, 1023));
               end
            end
            MIX_CHURN: begin
               n = $urandom_range(100, 200);
               repeat (n) queue_req(1'($urandom_range(0, 1)), pick_len(),
                                    $urandom_range(0, 1023));
            end
            default: begin
               n = $urandom_range(2, 8);
               repeat (n) begin
                  page = $urandom_range(0, PAGES - 1);
                  for (int k = 0; k < bra_pkg::PAGE_SLOTS / 8; k++)
                     queue_req(bra_pkg::CMD_FREE, 8, page * bra_pkg::PAGE_SLOTS + k * 8);
               end
               repeat (20) queue_req(bra_pkg::CMD_FREE, pick_len(), $urandom_range(0, 1023));
            end
         endcase
         mix = mix_type'($urandom_range(0, 2));
      end
      while (req_backlog.size() > ITEMS) void'(req_backlog.pop_back());

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (req_backlog.size() > 0 || req_valid || predicted_grants.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);

      $display("tb_top: %0d result beats checked; %0d no-space, %0d bad-length",
               beats_checked, no_space, bad_len);
      $display("tb_top: %0d allocate and %0d free beats with legal lengths",
               granted, frees);
      if (error_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

   initial begin
      #8ms;
      $display("tb_top: timeout");
      $display("tb_top: done, errors");
      $finish;
   end

endmodule

[files.f]
rtl/core/bra_pkg.sv
rtl/core/bra_ram.sv
rtl/core/bra_scan.sv
rtl/core/bitmap_run_allocator.sv
tb/tb_top.sv
